[sv/priority_ready_queue_scheduler_unit_defines.svh]
// assertion macros for the ready queue scheduler
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define PRQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define PRQS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/prqs_pkg.sv]
// shared types and constants of the ready queue scheduler
`default_nettype none
package prqs_pkg;

    localparam int PRQS_NUM_TASKS   = 64;
    localparam int PRQS_PRIO_LEVELS = 64;

    localparam int FUNC_W  = 3;
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 32;

    localparam logic [CFG_W-1:0] TICK_LENGTH_RST   = 32'd1000000;
    localparam logic [CFG_W-1:0] DEFAULT_SLICE_RST = 32'd10000000;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 3'd0,
        FUNC_REMOVE  = 3'd1,
        FUNC_WAKEUP  = 3'd2,
        FUNC_SLEEP   = 3'd3,
        FUNC_SETPRIO = 3'd4,
        FUNC_SCHED   = 3'd5,
        FUNC_TICK    = 3'd6
    } t_func;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TICK_LENGTH   = 1'b0,
        CFG_DEFAULT_SLICE = 1'b1
    } t_cfg_reg;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DEC,
        ST_TAIL,
        ST_ENQ,
        ST_ENQ_LINK,
        ST_LINK,
        ST_DEQ,
        ST_PICK,
        ST_HEAD,
        ST_TAKE,
        ST_DONE
    } t_state;

    // datapath steps
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_ACCEPT,
        STEP_LOAD,
        STEP_DEC,
        STEP_TAIL_RD,
        STEP_ENQ,
        STEP_ENQ_LINK,
        STEP_LINK_RD,
        STEP_DEQ,
        STEP_PICK,
        STEP_HEAD_RD,
        STEP_TAKE,
        STEP_OUT
    } t_step;

    typedef struct packed {
        t_step step;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  go_enq;
        logic  go_deq;
        logic  go_pick;
        logic  tail_null;
        logic  bm_empty;
        logic  out_free;
    } t_stat;

endpackage
`default_nettype wire

[sv/prqs_if.sv]
// handshake channels: request words, result words, configuration writes
`default_nettype none
interface prqs_in_if import prqs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [TASK_W-1:0]        task_req;
    logic signed [PRIO_W-1:0] prio;
    modport source (output valid, func, task_req, prio, input ready);
    modport sink   (input valid, func, task_req, prio, output ready);
endinterface

interface prqs_out_if import prqs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               status;
    logic [TASK_W-1:0]  next_task;
    logic               next_is_idle;
    logic               switched;
    logic               resched;
    logic [COUNT_W-1:0] ready_count;
    modport source (output valid, status, next_task, next_is_idle, switched, resched,
                    ready_count, input ready);
    modport sink   (input valid, status, next_task, next_is_idle, switched, resched,
                    ready_count, output ready);
endinterface

interface prqs_cfg_if import prqs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [0:0]       idx;
    logic [CFG_W-1:0] data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

[sv/prqs_ctrl.sv]
// sequencer of the scheduler: steps the datapath through one operation
`default_nettype none
module prqs_ctrl import prqs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and step
    always_comb begin
        n_state    = r_state;
        o_cmd.step = STEP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = STEP_ACCEPT;
                    n_state    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.step = STEP_LOAD;
                n_state    = ST_DEC;
            end
            ST_DEC: begin
                o_cmd.step = STEP_DEC;
                priority if (i_stat.go_deq) begin
                    n_state = ST_LINK;
                end else if (i_stat.go_enq) begin
                    n_state = ST_TAIL;
                end else if (i_stat.go_pick) begin
                    n_state = ST_PICK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_TAIL: begin
                o_cmd.step = STEP_TAIL_RD;
                n_state    = ST_ENQ;
            end
            ST_ENQ: begin
                o_cmd.step = STEP_ENQ;
                priority if (!i_stat.tail_null) begin
                    n_state = ST_ENQ_LINK;
                end else if (i_stat.func == FUNC_SCHED) begin
                    n_state = ST_PICK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ENQ_LINK: begin
                o_cmd.step = STEP_ENQ_LINK;
                n_state    = (i_stat.func == FUNC_SCHED) ? ST_PICK : ST_DONE;
            end
            ST_LINK: begin
                o_cmd.step = STEP_LINK_RD;
                n_state    = ST_DEQ;
            end
            ST_DEQ: begin
                o_cmd.step = STEP_DEQ;
                n_state    = (i_stat.func == FUNC_SETPRIO) ? ST_TAIL : ST_DONE;
            end
            ST_PICK: begin
                o_cmd.step = STEP_PICK;
                n_state    = i_stat.bm_empty ? ST_DONE : ST_HEAD;
            end
            ST_HEAD: begin
                o_cmd.step = STEP_HEAD_RD;
                n_state    = ST_TAKE;
            end
            ST_TAKE: begin
                o_cmd.step = STEP_TAKE;
                n_state    = ST_LINK;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.step = STEP_OUT;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/prqs_dp.sv]
// scheduler datapath: task tables, level lists, bitmap and result register
`default_nettype none
module prqs_dp import prqs_pkg::*; #(
    parameter int NUM_TASKS   = PRQS_NUM_TASKS,
    parameter int PRIO_LEVELS = PRQS_PRIO_LEVELS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic [TASK_W-1:0]        i_task_req,
    input  wire logic signed [PRIO_W-1:0] i_prio,
    input  wire logic                     i_cfg_we,
    input  wire logic [0:0]               i_cfg_idx,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_status,
    output logic [TASK_W-1:0]             o_next_task,
    output logic                          o_next_is_idle,
    output logic                          o_switched,
    output logic                          o_resched,
    output logic [COUNT_W-1:0]            o_ready_count
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int KW = $clog2(NUM_TASKS + 1);
    localparam int LW = $clog2(PRIO_LEVELS);
    localparam logic [KW-1:0] LNULL = KW'(NUM_TASKS);
    localparam logic signed [9:0] PMAX = 10'(PRIO_LEVELS - 1);

    // control state
    t_func             r_func;
    logic [IW-1:0]     r_wt;
    logic              r_ok;
    logic [LW-1:0]     r_nl;
    logic [LW-1:0]     r_wl;
    logic              r_st;
    logic              r_sw;
    logic [IW-1:0]     r_cur;
    logic              r_idle;
    logic              r_idle_resched;
    logic [KW-1:0]     r_count;
    logic [PRIO_LEVELS-1:0] r_bitmap;
    logic [NUM_TASKS-1:0]   r_queued;
    logic [NUM_TASKS-1:0]   r_runnable;
    logic [NUM_TASKS-1:0]   r_resched;
    logic [NUM_TASKS-1:0]   r_level_vld;
    logic [NUM_TASKS-1:0]   r_slice_vld;
    logic [PRIO_LEVELS-1:0] r_head_vld;
    logic [PRIO_LEVELS-1:0] r_tail_vld;
    logic [CFG_W-1:0]  r_tick_len;
    logic [CFG_W-1:0]  r_def_slice;
    logic              r_ov;

    // memories and their read registers
    logic [LW-1:0]    r_level_mem [NUM_TASKS];
    logic [CFG_W-1:0] r_slice_mem [NUM_TASKS];
    logic [KW-1:0]    r_next_mem  [NUM_TASKS];
    logic [KW-1:0]    r_prev_mem  [NUM_TASKS];
    logic [KW-1:0]    r_head_mem  [PRIO_LEVELS];
    logic [KW-1:0]    r_tail_mem  [PRIO_LEVELS];
    logic [LW-1:0]    r_level_q;
    logic             r_level_qv;
    logic [CFG_W-1:0] r_slice_q;
    logic             r_slice_qv;
    logic [KW-1:0]    r_next_q;
    logic [KW-1:0]    r_prev_q;
    logic [KW-1:0]    r_head_q;
    logic             r_head_qv;
    logic [KW-1:0]    r_tail_q;
    logic             r_tail_qv;

    // output word
    logic               r_o_status;
    logic [TASK_W-1:0]  r_o_task;
    logic               r_o_idle;
    logic               r_o_sw;
    logic               r_o_resched;
    logic [COUNT_W-1:0] r_o_count;

    logic [31:0]      task32;
    logic [IW-1:0]    t_in;
    logic             t_ok;
    logic             is_cur_op;
    logic signed [9:0] prio_x;
    logic [LW-1:0]    clamped;
    logic [LW-1:0]    lvl_rd;
    logic [CFG_W-1:0] slice_rd;
    logic [KW-1:0]    tail_rd;
    logic [KW-1:0]    head_rd;
    logic             q_wt;
    logic             run_wt;
    logic             requeue;
    logic             ign;
    logic             go_enq;
    logic             go_deq;
    logic             go_pick;
    logic [LW-1:0]    enc;
    logic             slice_gt;
    logic             p_null;
    logic             n_null;
    logic             lvl_wr;

    // request task id and clamped level
    always_comb begin
        task32    = 32'(i_task_req);
        t_in      = task32[IW-1:0];
        t_ok      = task32 < 32'(NUM_TASKS);
        is_cur_op = (t_func'(i_func) == FUNC_SCHED) || (t_func'(i_func) == FUNC_TICK);
        prio_x    = 10'(i_prio);
        if (prio_x < 10'sd0) begin
            clamped = '0;
        end else if (prio_x > PMAX) begin
            clamped = PMAX[LW-1:0];
        end else begin
            clamped = prio_x[LW-1:0];
        end
    end

    // read data with reset values for entries never written
    assign lvl_rd   = r_level_qv ? r_level_q : '0;
    assign slice_rd = r_slice_qv ? r_slice_q : '0;
    assign tail_rd  = r_tail_qv ? r_tail_q : LNULL;
    assign head_rd  = r_head_qv ? r_head_q : LNULL;
    assign q_wt     = r_queued[r_wt];
    assign run_wt   = r_runnable[r_wt];
    assign requeue  = !r_idle && run_wt && !q_wt;
    assign slice_gt = slice_rd > r_tick_len;
    assign p_null   = r_prev_q == LNULL;
    assign n_null   = r_next_q == LNULL;

    // operation decode
    always_comb begin
        ign     = 1'b0;
        go_enq  = 1'b0;
        go_deq  = 1'b0;
        go_pick = 1'b0;
        unique case (r_func)
            FUNC_ADD: begin
                ign    = !r_ok || q_wt;
                go_enq = !ign;
            end
            FUNC_REMOVE: begin
                ign    = !r_ok || !q_wt;
                go_deq = !ign;
            end
            FUNC_WAKEUP: begin
                ign    = !r_ok || run_wt;
                go_enq = !ign && !q_wt;
            end
            FUNC_SLEEP: begin
                ign    = !r_ok || !run_wt;
                go_deq = !ign && q_wt;
            end
            FUNC_SETPRIO: begin
                ign    = !r_ok;
                go_deq = r_ok && q_wt;
            end
            FUNC_SCHED: begin
                go_enq  = requeue;
                go_pick = !requeue;
            end
            FUNC_TICK: begin
                ign = 1'b0;
            end
            default: begin
                ign = 1'b1;
            end
        endcase
    end

    assign lvl_wr = ((r_func == FUNC_ADD) && !ign) || ((r_func == FUNC_SETPRIO) && r_ok);

    // lowest non-empty level
    always_comb begin
        enc = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
            if (r_bitmap[i]) begin
                enc = LW'(i);
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.func      = r_func;
        o_stat.go_enq    = go_enq;
        o_stat.go_deq    = go_deq;
        o_stat.go_pick   = go_pick;
        o_stat.tail_null = tail_rd == LNULL;
        o_stat.bm_empty  = ~|r_bitmap;
        o_stat.out_free  = !r_ov || i_out_ready;
    end

    // control state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur          <= '0;
            r_idle         <= 1'b1;
            r_idle_resched <= 1'b0;
            r_count        <= '0;
            r_bitmap       <= '0;
            r_queued       <= '0;
            r_runnable     <= '0;
            r_resched      <= '0;
            r_level_vld    <= '0;
            r_slice_vld    <= '0;
            r_head_vld     <= '0;
            r_tail_vld     <= '0;
            r_tick_len     <= TICK_LENGTH_RST;
            r_def_slice    <= DEFAULT_SLICE_RST;
            r_ov           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_TICK_LENGTH:   r_tick_len  <= i_cfg_data;
                    CFG_DEFAULT_SLICE: r_def_slice <= i_cfg_data;
                    default:           r_tick_len  <= r_tick_len;
                endcase
            end
            unique case (i_cmd.step)
                STEP_DEC: begin
                    r_ov <= r_ov && !i_out_ready;
                    if (lvl_wr) begin
                        r_level_vld[r_wt] <= 1'b1;
                    end
                    unique case (r_func)
                        FUNC_ADD: begin
                            if (!ign) r_runnable[r_wt] <= 1'b1;
                        end
                        FUNC_WAKEUP: begin
                            if (!ign) begin
                                r_runnable[r_wt]  <= 1'b1;
                                r_slice_vld[r_wt] <= 1'b1;
                            end
                        end
                        FUNC_SLEEP: begin
                            if (!ign) r_runnable[r_wt] <= 1'b0;
                        end
                        FUNC_TICK: begin
                            if (r_idle) begin
                                if (r_count != '0) r_idle_resched <= 1'b1;
                            end else begin
                                r_slice_vld[r_wt] <= 1'b1;
                                if (!slice_gt) r_resched[r_wt] <= 1'b1;
                            end
                        end
                        default: begin
                            r_idle_resched <= r_idle_resched;
                        end
                    endcase
                end
                STEP_ENQ: begin
                    r_ov             <= r_ov && !i_out_ready;
                    r_bitmap[r_wl]   <= 1'b1;
                    r_queued[r_wt]   <= 1'b1;
                    r_count          <= r_count + KW'(1);
                    r_tail_vld[r_wl] <= 1'b1;
                    if (tail_rd == LNULL) r_head_vld[r_wl] <= 1'b1;
                end
                STEP_DEQ: begin
                    r_ov           <= r_ov && !i_out_ready;
                    r_queued[r_wt] <= 1'b0;
                    r_count        <= r_count - KW'(1);
                    if (p_null && n_null) r_bitmap[r_wl] <= 1'b0;
                    if (p_null) r_head_vld[r_wl] <= 1'b1;
                    if (n_null) r_tail_vld[r_wl] <= 1'b1;
                    if (r_func == FUNC_SCHED) begin
                        r_cur            <= r_wt;
                        r_idle           <= 1'b0;
                        r_resched[r_wt]  <= 1'b0;
                    end
                end
                STEP_PICK: begin
                    r_ov <= r_ov && !i_out_ready;
                    if (~|r_bitmap) begin
                        r_idle         <= 1'b1;
                        r_cur          <= '0;
                        r_idle_resched <= 1'b0;
                    end
                end
                STEP_OUT: begin
                    r_ov <= 1'b1;
                end
                default: begin
                    r_ov <= r_ov && !i_out_ready;
                end
            endcase
        end
    end

    // work registers and result word
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            STEP_ACCEPT: begin
                r_func <= t_func'(i_func);
                r_wt   <= is_cur_op ? r_cur : t_in;
                r_ok   <= is_cur_op || t_ok;
                r_nl   <= clamped;
                r_sw   <= 1'b0;
            end
            STEP_DEC: begin
                r_st <= ign;
                r_wl <= (r_func == FUNC_ADD) ? r_nl : lvl_rd;
            end
            STEP_DEQ: begin
                if (r_func == FUNC_SETPRIO) r_wl <= r_nl;
                if (r_func == FUNC_SCHED) r_sw <= r_idle || (r_cur != r_wt);
            end
            STEP_PICK: begin
                r_wl <= enc;
                if (~|r_bitmap) r_sw <= !r_idle;
            end
            STEP_TAKE: begin
                r_wt <= head_rd[IW-1:0];
            end
            STEP_OUT: begin
                r_o_status  <= r_st;
                r_o_task    <= r_idle ? '0 : TASK_W'(r_cur);
                r_o_idle    <= r_idle;
                r_o_sw      <= r_sw;
                r_o_resched <= r_idle ? r_idle_resched : r_resched[r_cur];
                r_o_count   <= COUNT_W'(r_count);
            end
            default: begin
                r_wl <= r_wl;
            end
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            STEP_LOAD: begin
                r_level_q  <= r_level_mem[r_wt];
                r_level_qv <= r_level_vld[r_wt];
                r_slice_q  <= r_slice_mem[r_wt];
                r_slice_qv <= r_slice_vld[r_wt];
            end
            STEP_DEC: begin
                if (lvl_wr) r_level_mem[r_wt] <= r_nl;
                if ((r_func == FUNC_WAKEUP) && !ign) begin
                    r_slice_mem[r_wt] <= r_def_slice;
                end else if ((r_func == FUNC_TICK) && !r_idle) begin
                    r_slice_mem[r_wt] <= slice_gt ? (slice_rd - r_tick_len) : r_def_slice;
                end
            end
            STEP_TAIL_RD: begin
                r_tail_q  <= r_tail_mem[r_wl];
                r_tail_qv <= r_tail_vld[r_wl];
            end
            STEP_ENQ: begin
                r_next_mem[r_wt] <= LNULL;
                r_prev_mem[r_wt] <= tail_rd;
                r_tail_mem[r_wl] <= KW'(r_wt);
                if (tail_rd == LNULL) r_head_mem[r_wl] <= KW'(r_wt);
            end
            STEP_ENQ_LINK: begin
                r_next_mem[tail_rd[IW-1:0]] <= KW'(r_wt);
            end
            STEP_LINK_RD: begin
                r_next_q <= r_next_mem[r_wt];
                r_prev_q <= r_prev_mem[r_wt];
            end
            STEP_DEQ: begin
                if (p_null) r_head_mem[r_wl] <= r_next_q;
                else r_next_mem[r_prev_q[IW-1:0]] <= r_next_q;
                if (n_null) r_tail_mem[r_wl] <= r_prev_q;
                else r_prev_mem[r_next_q[IW-1:0]] <= r_prev_q;
            end
            STEP_HEAD_RD: begin
                r_head_q  <= r_head_mem[r_wl];
                r_head_qv <= r_head_vld[r_wl];
            end
            default: begin
                r_tail_q <= r_tail_q;
            end
        endcase
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_next_task    = r_o_task;
    assign o_next_is_idle = r_o_idle;
    assign o_switched     = r_o_sw;
    assign o_resched      = r_o_resched;
    assign o_ready_count  = r_o_count;

endmodule
`default_nettype wire

[sv/priority_ready_queue_scheduler_unit.sv]
// top level of the priority ready queue scheduler
// One request word is worked at a time and gives one result word. Ignored words, tick
// and set priority of an unqueued task touch no list; schedule with nothing waiting
// only encodes the empty bitmap. Remove and sleep unlink the task; add and wakeup link
// it at the tail of its level, with a further link write when the level already holds
// a task; set priority of a queued task unlinks and relinks it; schedule does requeue
// of the current task, bitmap encode, head read, unlink. The block returns to idle
// before the next word is taken, and a result not yet taken holds the block. The steps
// follow from the single read/write port of each link and list memory, whose reads are
// registered. List heads, tails, levels and slices carry valid bits, so reset needs no sweep.
// Configuration writes are always taken and must arrive while no word is in work.
`default_nettype none
`include "priority_ready_queue_scheduler_unit_defines.svh"
module priority_ready_queue_scheduler_unit import prqs_pkg::*; #(
    parameter int NUM_TASKS   = PRQS_NUM_TASKS,
    parameter int PRIO_LEVELS = PRQS_PRIO_LEVELS
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    prqs_in_if.sink     i_in,
    prqs_out_if.source  o_out,
    prqs_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer
    prqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // tables, lists and result register
    prqs_dp #(
        .NUM_TASKS   (NUM_TASKS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_in.func),
        .i_task_req     (i_in.task_req),
        .i_prio         (i_in.prio),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_idx      (i_cfg.idx),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_next_task    (o_out.next_task),
        .o_next_is_idle (o_out.next_is_idle),
        .o_switched     (o_out.switched),
        .o_resched      (o_out.resched),
        .o_ready_count  (o_out.ready_count)
    );

    // checks
    `PRQS_ASSERT_IMP(a_idle_task_zero, o_out.valid && o_out.next_is_idle, o_out.next_task == '0, "idle result with nonzero task")
    `PRQS_ASSERT_NXT(a_busy_after_accept, i_in.valid && w_in_ready, !w_in_ready, "word accepted while busy")
    `PRQS_ASSERT_IMP(a_count_range, o_out.valid, 32'(o_out.ready_count) <= 32'(NUM_TASKS), "ready count beyond task count")

endmodule
`default_nettype wire
